/* rtl/dlne_pkg.sv */
// shared constants for the dns label name encoder
package dlne_pkg;

   localparam int LABEL_MAX = 63;

   localparam int CH_W    = 8;
   localparam int LEN_W   = 6;
   localparam int COUNT_W = 2;

   // wire positions run from the length byte at 0 up to the terminator at LABEL_MAX + 1
   localparam int POS_W    = LEN_W + 1;
   localparam int ROW_W    = POS_W - 1;
   localparam int MEM_ROWS = LABEL_MAX / 2 + 1;
   localparam int MEM_AW   = ROW_W - 1;

   localparam logic [CH_W-1:0] CH_END = 8'd0;
   localparam logic [CH_W-1:0] CH_DOT = 8'd46;

   localparam logic [COUNT_W-1:0] COUNT_ONE = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO = 2'd2;

   typedef logic [1:0][CH_W-1:0] row_type;

   // row request travelling from the read port to the output register
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [LEN_W-1:0] len;
      logic             term;
      logic             cut;
      logic             last;
   } row_req_type;

endpackage

/* rtl/dns_label_name_encoder.sv */
// dns label name encoder top level
// Characters of a dotted name enter one per cycle while req_ready is high and are written
// into a 32 x 16-bit label memory in wire order, two bytes to a row. The end of the name (a
// zero character), or a dot closing a non-empty label while the name is not stopped, starts
// a drain: the memory is read one row per cycle through its single read port while the read
// and output stages can advance, and each row leaves as one result of up to two bytes, the
// length byte in front and the zero terminator at the end of the name. A label of n characters
// gives ceil((n + 1) / 2) results, ceil((n + 2) / 2) at the end of the name, each passing the
// read stage and the output register. req_ready is low after the drain starts until the last
// row read has been issued, so the input stalls while the drain issues its reads, and longer
// while rsp_ready holds those stages; their last results may wait as the next label enters.
// There is no clearing pass after reset.
module dns_label_name_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dlne_pkg::CH_W-1:0]     req_ch,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dlne_pkg::CH_W-1:0]     rsp_byte_a,
   output logic [dlne_pkg::CH_W-1:0]     rsp_byte_b,
   output logic [dlne_pkg::COUNT_W-1:0]  rsp_byte_count,
   output logic                          rsp_run_last,
   output logic                          rsp_label_cut
);
   import dlne_pkg::*;

   // label memory, lane 0 holds even wire positions
   row_type mem [MEM_ROWS];
   row_type rdata_ff;

   // collection state
   logic [LEN_W-1:0] len_ff, len_in;
   logic             halted_ff, halted_in;
   logic             cutflag_ff, cutflag_in;

   // drain state
   logic             drain_ff, drain_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] lastrow_ff, lastrow_in;
   logic [LEN_W-1:0] dlen_ff, dlen_in;
   logic             dterm_ff, dterm_in;
   logic             dcut_ff, dcut_in;

   // read stage
   logic             s1_valid_ff, s1_valid_in;
   row_req_type      s1_ff, s1_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [CH_W-1:0]    out_a_ff, out_a_in;
   logic [CH_W-1:0]    out_b_ff, out_b_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic               out_last_ff, out_last_in;
   logic               out_cut_ff, out_cut_in;

   logic             accept, is_end, is_dot, is_char, start, wr_en;
   logic [LEN_W-1:0] wr_pos;
   logic [LEN_W-1:0] start_len;
   logic [POS_W-1:0] start_lab, start_nb;
   logic [ROW_W-1:0] start_nres;
   logic             adv_out, adv_s1, issue;
   logic [POS_W-1:0] f_lab, f_nb, f_pa, f_pb;
   logic             f_hasb;

   assign req_ready = !drain_ff;
   assign accept    = req_valid && req_ready;
   assign is_end    = req_ch == CH_END;
   assign is_dot    = req_ch == CH_DOT;
   assign is_char   = !is_end && !is_dot;

   // only written below LABEL_MAX, so the position stays within one row index
   assign wr_en  = accept && is_char && !halted_ff && (len_ff < LEN_W'(LABEL_MAX));
   assign wr_pos = len_ff + LEN_W'(1);

   assign start      = accept && (is_end || (is_dot && !halted_ff && len_ff != '0));
   assign start_len  = halted_ff ? '0 : len_ff;
   assign start_lab  = (start_len != '0) ? POS_W'(start_len) + POS_W'(1) : '0;
   assign start_nb   = start_lab + POS_W'(is_end);
   assign start_nres = ROW_W'((start_nb + POS_W'(1)) >> 1);

   assign adv_out = !out_valid_ff || rsp_ready;
   assign adv_s1  = !s1_valid_ff || adv_out;
   assign issue   = drain_ff && adv_s1;

   always_comb begin
      len_in     = len_ff;
      halted_in  = halted_ff;
      cutflag_in = cutflag_ff;
      if (accept) begin
         if (is_char) begin
            if (!halted_ff) begin
               if (len_ff < LEN_W'(LABEL_MAX)) begin
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  cutflag_in = 1'b1;
               end
            end
         end else if (is_dot && !halted_ff && len_ff == '0) begin
            halted_in = 1'b1;
         end else if (start) begin
            len_in     = '0;
            cutflag_in = 1'b0;
            if (is_end) begin
               halted_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      drain_in   = drain_ff;
      row_in     = row_ff;
      lastrow_in = lastrow_ff;
      dlen_in    = dlen_ff;
      dterm_in   = dterm_ff;
      dcut_in    = dcut_ff;
      if (start) begin
         drain_in   = 1'b1;
         row_in     = '0;
         lastrow_in = start_nres - ROW_W'(1);
         dlen_in    = start_len;
         dterm_in   = is_end;
         dcut_in    = cutflag_ff && !halted_ff;
      end else if (issue) begin
         row_in = row_ff + ROW_W'(1);
         if (row_ff == lastrow_ff) begin
            drain_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (adv_s1) begin
         s1_valid_in = issue;
         s1_in.row   = row_ff;
         s1_in.len   = dlen_ff;
         s1_in.term  = dterm_ff;
         s1_in.cut   = dcut_ff;
         s1_in.last  = row_ff == lastrow_ff;
      end
   end

   // pack one row of the wire stream
   always_comb begin
      f_lab  = (s1_ff.len != '0) ? POS_W'(s1_ff.len) + POS_W'(1) : '0;
      f_nb   = f_lab + POS_W'(s1_ff.term);
      f_pa   = {s1_ff.row, 1'b0};
      f_pb   = {s1_ff.row, 1'b1};
      f_hasb = f_pb < f_nb;

      out_valid_in = out_valid_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      out_cut_in   = out_cut_ff;
      if (adv_out) begin
         out_valid_in = s1_valid_ff;
         if (f_pa < f_lab) begin
            out_a_in = (f_pa == '0) ? CH_W'(s1_ff.len) : rdata_ff[0];
         end else begin
            out_a_in = '0;
         end
         out_b_in     = (f_hasb && f_pb < f_lab) ? rdata_ff[1] : '0;
         out_count_in = f_hasb ? COUNT_TWO : COUNT_ONE;
         out_last_in  = s1_ff.last;
         out_cut_in   = s1_ff.cut && (f_pa < f_lab);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_pos[LEN_W-1:1]][wr_pos[0]] <= req_ch;
      end
      if (issue) begin
         rdata_ff <= mem[row_ff[MEM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         halted_ff    <= 1'b0;
         cutflag_ff   <= 1'b0;
         drain_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         halted_ff    <= halted_in;
         cutflag_ff   <= cutflag_in;
         drain_ff     <= drain_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      lastrow_ff   <= lastrow_in;
      dlen_ff      <= dlen_in;
      dterm_ff     <= dterm_in;
      dcut_ff      <= dcut_in;
      s1_ff        <= s1_in;
      out_a_ff     <= out_a_in;
      out_b_ff     <= out_b_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
      out_cut_ff   <= out_cut_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_a     = out_a_ff;
   assign rsp_byte_b     = out_b_ff;
   assign rsp_byte_count = out_count_ff;
   assign rsp_run_last   = out_last_ff;
   assign rsp_label_cut  = out_cut_ff;

endmodule

/* rtl/dlne_checker.sv */
// port checker for the dns label name encoder and its bind
module dlne_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dlne_pkg::CH_W-1:0]     rsp_byte_a,
   input logic [dlne_pkg::CH_W-1:0]     rsp_byte_b,
   input logic [dlne_pkg::COUNT_W-1:0]  rsp_byte_count,
   input logic                          rsp_run_last
);
   import dlne_pkg::*;

   // only the closing result of a run may carry a single byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == COUNT_ONE |-> rsp_run_last)
      else $error("single byte result before end of run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count == COUNT_ONE || rsp_byte_count == COUNT_TWO)
      else $error("bad byte count");

   // a single byte result holds its byte in the first lane and leaves the unused second byte zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == COUNT_ONE |-> rsp_byte_b == '0)
      else $error("unused second byte not zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_a) && $stable(rsp_byte_b))
      else $error("stalled result changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind dns_label_name_encoder dlne_checker u_dlne_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_byte_a     (rsp_byte_a),
   .rsp_byte_b     (rsp_byte_b),
   .rsp_byte_count (rsp_byte_count),
   .rsp_run_last   (rsp_run_last)
);

/* sim/tb_dns_label_name_encoder.sv */
// testbench for the dns label name encoder: random and directed names checked against a predictor
`timescale 1ns / 100ps

module tb_dns_label_name_encoder;
   import dlne_pkg::*;

   localparam int IDLE_PCT    = 27;
   localparam int IDLE_LIMIT  = 1000;
   localparam int HOLD_AT     = 40;
   localparam int HOLD_CYCLES = 150;
   localparam int CALM_FROM   = 250;
   localparam int CALM_TO     = 450;
   localparam int N_ITEMS     = 160;
   localparam int DRAIN_WAIT  = 20;

   typedef struct {
      logic [CH_W-1:0]    byte_a;
      logic [CH_W-1:0]    byte_b;
      logic [COUNT_W-1:0] byte_count;
      logic               run_last;
      logic               label_cut;
   } wire_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CH_W-1:0]     req_ch = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CH_W-1:0]     rsp_byte_a;
   logic [CH_W-1:0]     rsp_byte_b;
   logic [COUNT_W-1:0]  rsp_byte_count;
   logic                rsp_run_last;
   logic                rsp_label_cut;

   // pending requests and the encoded words they must produce
   logic [CH_W-1:0] char_queue[$];
   wire_word_type   encoded_due[$];
   wire_word_type   due;

   // predictor state
   logic [CH_W-1:0] label_chars[LABEL_MAX];
   int              label_len = 0;
   bit              name_halted = 1'b0;
   bit              label_cut_seen = 1'b0;

   int   chars_taken = 0;
   int   total_chars = 0;
   int   mismatches = 0;
   int   idle_cycles = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   logic req_acc = 1'b0;
   logic calm;

   assign calm = cycle_count >= CALM_FROM && cycle_count < CALM_TO;

   dns_label_name_encoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_a     (rsp_byte_a),
      .rsp_byte_b     (rsp_byte_b),
      .rsp_byte_count (rsp_byte_count),
      .rsp_run_last   (rsp_run_last),
      .rsp_label_cut  (rsp_label_cut)
   );

   always #5 clock = ~clock;

   function automatic void encode_char(logic [CH_W-1:0] ch);
      logic [CH_W-1:0] out_bytes[$];
      int              n_label;
      int              n_words;
      bit              was_cut;
      wire_word_type   w;
      was_cut = label_cut_seen;
      n_label = 0;
      if (ch != CH_END && ch != CH_DOT) begin
         if (!name_halted) begin
            if (label_len < LABEL_MAX) begin
               label_chars[label_len] = ch;
               label_len++;
            end else begin
               label_cut_seen = 1'b1;
            end
         end
         return;
      end
      // a dot on an empty label stops the name; further dots change nothing
      if (ch == CH_DOT && (name_halted || label_len == 0)) begin
         name_halted = 1'b1;
         return;
      end
      if (!name_halted && label_len > 0) begin
         out_bytes.push_back(CH_W'(label_len));
         for (int i = 0; i < label_len; i++) out_bytes.push_back(label_chars[i]);
         n_label = out_bytes.size();
      end
      label_len = 0;
      label_cut_seen = 1'b0;
      if (ch == CH_END) begin
         out_bytes.push_back(CH_END);
         name_halted = 1'b0;
      end
      n_words = (out_bytes.size() + 1) / 2;
      for (int k = 0; k < n_words; k++) begin
         w.byte_a = out_bytes[2*k];
         if (2*k + 1 < out_bytes.size()) begin
            w.byte_b = out_bytes[2*k+1];
            w.byte_count = COUNT_TWO;
         end else begin
            w.byte_b = '0;
            w.byte_count = COUNT_ONE;
         end
         w.run_last = (k + 1 == n_words);
         w.label_cut = was_cut && (2*k < n_label);
         encoded_due.push_back(w);
      end
   endfunction

   function automatic logic [CH_W-1:0] rand_label_char();
      logic [CH_W-1:0] v;
      do v = CH_W'($urandom_range(1, 255)); while (v == CH_DOT);
      return v;
   endfunction

   function automatic void push_label(int n);
      for (int i = 0; i < n; i++) char_queue.push_back(rand_label_char());
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) char_queue.push_back(CH_W'(s[i]));
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_acc) begin
         if (char_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_ch    <= char_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off once the name stream is under way
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && chars_taken >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      req_acc <= !reset && req_valid && req_ready;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_valid && req_ready) begin
            encode_char(req_ch);
            chars_taken <= chars_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (encoded_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: a=%h b=%h n=%0d last=%b cut=%b",
                           rsp_byte_a, rsp_byte_b, rsp_byte_count, rsp_run_last,
                           rsp_label_cut);
               mismatches++;
            end else begin
               due = encoded_due.pop_front();
               if (rsp_byte_a !== due.byte_a || rsp_byte_count !== due.byte_count ||
                   rsp_run_last !== due.run_last || rsp_label_cut !== due.label_cut ||
                   (due.byte_count == COUNT_TWO && rsp_byte_b !== due.byte_b)) begin
                  if (mismatches < 10)
                     $display("mismatch: exp %h %h %0d %b %b, got %h %h %0d %b %b",
                              due.byte_a, due.byte_b, due.byte_count, due.run_last,
                              due.label_cut, rsp_byte_a, rsp_byte_b, rsp_byte_count,
                              rsp_run_last, rsp_label_cut);
                  mismatches++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int  n_labels;
      int  len;
      int  r;

      // empty name, leading dot
      char_queue.push_back(CH_END);
      push_text(".");
      char_queue.push_back(CH_END);
      // extreme label bytes, two labels
      char_queue.push_back(8'hff);
      push_text(".");
      char_queue.push_back(8'h01);
      char_queue.push_back(8'h7f);
      char_queue.push_back(CH_END);
      // trailing dot
      push_text("a.");
      char_queue.push_back(CH_END);
      // doubled dot, then characters and a dot while stopped
      push_text("ab..c.d");
      char_queue.push_back(CH_END);
      // odd label length, terminator alone in the last word
      push_text("abc");
      char_queue.push_back(CH_END);
      // label fills the memory and one more character is cut
      push_label(LABEL_MAX + 1);
      char_queue.push_back(CH_END);

      while (char_queue.size() < N_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            n_labels = $urandom_range(1, 4);
            for (int j = 0; j < n_labels; j++) begin
               len = $urandom_range(1, 10);
               push_label(len);
               if (j < n_labels - 1 || $urandom_range(0, 9) == 0) char_queue.push_back(CH_DOT);
            end
            char_queue.push_back(CH_END);
         end else begin
            // noise: dots and stray ends mixed into arbitrary bytes
            len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++) begin
               r = $urandom_range(0, 9);
               if (r < 3) char_queue.push_back(CH_DOT);
               else if (r == 3) char_queue.push_back(CH_END);
               else char_queue.push_back(CH_W'($urandom_range(0, 255)));
            end
            char_queue.push_back(CH_END);
         end
      end
      total_chars = char_queue.size();

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (chars_taken < total_chars || encoded_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (mismatches == 0 && encoded_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* dns_label_name_encoder.f */
rtl/dlne_pkg.sv
rtl/dns_label_name_encoder.sv
rtl/dlne_checker.sv
sim/tb_dns_label_name_encoder.sv
